>>> rtl/core/nsr_pkg.sv
// nsr_pkg: widths, constants, register indexes and controller types
// shared by the newton square root block; no dependencies
package nsr_pkg;

  localparam int EST_W    = 32;
  localparam int TARGET_W = 48;
  localparam int SQ_W     = 2 * EST_W;
  localparam int ROOT_W   = 24;
  localparam int STEPS_W  = 7;
  localparam int TOL_W    = 32;
  localparam int CFG_W    = 32;
  localparam int CFG_IDX_W = 1;
  localparam int FRAC_W   = 16;

  localparam logic [EST_W-1:0]   ONE_Q16     = EST_W'(32'h0001_0000);
  localparam logic [ROOT_W-1:0]  ROOT_MAX    = {ROOT_W{1'b1}};
  localparam logic [STEPS_W-1:0] MAX_ITERATIONS = STEPS_W'(64);

  localparam logic [TOL_W-1:0]   TOL_RESET   = TOL_W'(2147);
  localparam logic [STEPS_W-1:0] LIMIT_RESET = STEPS_W'(64);

  // divider retires this many quotient bits per cycle
  localparam int DIV_BITS  = 2;
  localparam int DIV_STEPS = TARGET_W / DIV_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_DIFF,
    ST_TEST,
    ST_DIVIDE,
    ST_UPDATE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic square;
    logic diff;
    logic div_start;
    logic update;
    logic capture;
  } dp_cmd_t;

  typedef struct packed {
    logic close;
    logic est_zero;
    logic div_done;
  } dp_status_t;

endpackage

>>> rtl/core/nsr_divider.sv
// nsr_divider: unsigned 48-by-32 restoring divider, two quotient bits a cycle
// depends on nsr_pkg
module nsr_divider (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [nsr_pkg::TARGET_W-1:0]  dividend,
  input  logic [nsr_pkg::EST_W-1:0]     divisor,
  output logic [nsr_pkg::TARGET_W-1:0]  quotient,
  output logic                          done
);

  logic                            busy;
  logic [nsr_pkg::DIV_CNT_W-1:0]   cnt;
  logic [nsr_pkg::EST_W-1:0]       rem;
  logic [nsr_pkg::TARGET_W-1:0]    quo;
  logic [nsr_pkg::EST_W-1:0]       rem_next;
  logic [nsr_pkg::TARGET_W-1:0]    quo_next;

  // quo shifts dividend bits out at the top and quotient bits in at the bottom
  always_comb begin
    logic [nsr_pkg::EST_W:0] r;
    rem_next = rem;
    quo_next = quo;
    r = '0;
    for (int i = 0; i < nsr_pkg::DIV_BITS; i++) begin
      r = {rem_next, quo_next[nsr_pkg::TARGET_W-1]};
      quo_next = {quo_next[nsr_pkg::TARGET_W-2:0], 1'b0};
      if (r >= {1'b0, divisor}) begin
        r = r - {1'b0, divisor};
        quo_next[0] = 1'b1;
      end
      rem_next = r[nsr_pkg::EST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == nsr_pkg::DIV_CNT_W'(nsr_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  assign quotient = quo;

endmodule

>>> rtl/core/nsr_datapath.sv
// nsr_datapath: estimate, square, error and heron update registers
// depends on nsr_pkg and nsr_divider
module nsr_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  nsr_pkg::dp_cmd_t              cmd,
  input  logic [31:0]                   radicand,
  input  logic [nsr_pkg::TOL_W-1:0]     tolerance,
  output nsr_pkg::dp_status_t           status,
  output logic [nsr_pkg::ROOT_W-1:0]    root
);

  logic [nsr_pkg::TARGET_W-1:0] target;
  logic [nsr_pkg::EST_W-1:0]    est;
  logic [nsr_pkg::SQ_W-1:0]     sq;
  logic [nsr_pkg::SQ_W-1:0]     diff;
  logic [nsr_pkg::SQ_W-1:0]     target_wide;
  logic [nsr_pkg::SQ_W-1:0]     sq_full;
  logic [nsr_pkg::TARGET_W-1:0] quotient;
  logic [nsr_pkg::TARGET_W:0]   sum;
  logic [nsr_pkg::TARGET_W-1:0] mean;
  logic [nsr_pkg::EST_W-1:0]    est_next;
  logic                         div_done;

  nsr_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (target),
    .divisor  (est),
    .quotient (quotient),
    .done     (div_done)
  );

  assign target_wide = {{(nsr_pkg::SQ_W - nsr_pkg::TARGET_W){1'b0}}, target};
  assign sq_full     = est * est;

  // truncated mean, saturated to the estimate width
  assign sum  = {{(nsr_pkg::TARGET_W + 1 - nsr_pkg::EST_W){1'b0}}, est}
              + {1'b0, quotient};
  assign mean = sum[nsr_pkg::TARGET_W:1];
  assign est_next = (|mean[nsr_pkg::TARGET_W-1:nsr_pkg::EST_W]) ? {nsr_pkg::EST_W{1'b1}}
                                                                : mean[nsr_pkg::EST_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      target <= {radicand, {nsr_pkg::FRAC_W{1'b0}}};
      est    <= nsr_pkg::ONE_Q16;
    end else if (cmd.update) begin
      est <= est_next;
    end
    if (cmd.square) begin
      sq <= sq_full;
    end
    if (cmd.diff) begin
      diff <= (sq >= target_wide) ? (sq - target_wide) : (target_wide - sq);
    end
    if (cmd.capture) begin
      root <= (|est[nsr_pkg::EST_W-1:nsr_pkg::ROOT_W]) ? nsr_pkg::ROOT_MAX
                                                      : est[nsr_pkg::ROOT_W-1:0];
    end
  end

  assign status.close    = (diff <= {{(nsr_pkg::SQ_W - nsr_pkg::TOL_W){1'b0}}, tolerance});
  assign status.est_zero = (est == '0);
  assign status.div_done = div_done;

endmodule

>>> rtl/core/nsr_ctrl.sv
// nsr_ctrl: sequencer for square, error, test, divide and update, step counting and result beat
// depends on nsr_pkg
module nsr_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  output logic                          out_valid,
  input  logic                          out_stall,
  input  logic [nsr_pkg::STEPS_W-1:0]   iteration_limit,
  input  nsr_pkg::dp_status_t           status,
  output nsr_pkg::dp_cmd_t              cmd,
  output logic [nsr_pkg::STEPS_W-1:0]   steps_used,
  output logic                          converged
);

  nsr_pkg::state_t             state, state_next;
  logic [nsr_pkg::STEPS_W-1:0] steps;
  logic [nsr_pkg::STEPS_W-1:0] limit;
  logic                        ok;
  logic                        accept;

  assign in_stall = rst || (state != nsr_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nsr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      nsr_pkg::ST_IDLE: begin
        if (accept) begin
          cmd.load   = 1'b1;
          state_next = nsr_pkg::ST_SQUARE;
        end
      end
      nsr_pkg::ST_SQUARE: begin
        cmd.square = 1'b1;
        state_next = nsr_pkg::ST_DIFF;
      end
      nsr_pkg::ST_DIFF: begin
        cmd.diff   = 1'b1;
        state_next = nsr_pkg::ST_TEST;
      end
      nsr_pkg::ST_TEST: begin
        if (status.close || status.est_zero || steps >= limit) begin
          state_next = nsr_pkg::ST_FINISH;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = nsr_pkg::ST_DIVIDE;
        end
      end
      nsr_pkg::ST_DIVIDE: begin
        if (status.div_done) begin
          state_next = nsr_pkg::ST_UPDATE;
        end
      end
      nsr_pkg::ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = nsr_pkg::ST_SQUARE;
      end
      nsr_pkg::ST_FINISH: begin
        // hold the finished result until the output register is free
        if (!out_valid || !out_stall) begin
          cmd.capture = 1'b1;
          state_next  = nsr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = nsr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      steps     <= '0;
      limit     <= '0;
      ok        <= 1'b0;
    end else begin
      if (cmd.load) begin
        steps <= '0;
        limit <= (iteration_limit > nsr_pkg::MAX_ITERATIONS) ? nsr_pkg::MAX_ITERATIONS
                                                             : iteration_limit;
      end
      if (state == nsr_pkg::ST_TEST) begin
        ok <= status.close;
      end
      if (cmd.update) begin
        steps <= steps + 1'b1;
      end
      if (cmd.capture) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      steps_used <= steps;
      converged  <= ok;
    end
  end

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    (state == nsr_pkg::ST_DIVIDE) |-> (steps < limit))
    else $error("divide running with step budget used up");

  a_steps_max: assert property (@(posedge clk) disable iff (rst)
    steps <= nsr_pkg::MAX_ITERATIONS)
    else $error("step counter beyond maximum");

  a_capture_free: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |-> (!out_valid || !out_stall))
    else $error("result captured over a waiting beat");

  a_done_in_divide: assert property (@(posedge clk) disable iff (rst)
    status.div_done |-> (state == nsr_pkg::ST_DIVIDE))
    else $error("divider finished outside divide state");

  a_start_divide: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> (state == nsr_pkg::ST_DIVIDE) && !status.div_done)
    else $error("divide start not followed by divide wait");

endmodule

>>> rtl/core/newton_square_root.sv
// newton_square_root: top level with configuration registers
// depends on nsr_pkg, nsr_ctrl, nsr_datapath
//
// Square root of an unsigned Q16.16 radicand by Heron's iteration starting at 1.0.
// Input channel: radicand with in_valid / in_stall; a beat is taken when
// in_valid is high and in_stall low. Output channel: root, steps_used and
// converged with out_valid / out_stall, held steady while stalled.
// One item is worked on at a time. After an accepted beat the sequencer
// runs the square, the error and the tolerance test, then for each refinement
// step the radix-4 divider (two quotient bits per cycle over the 48-bit
// dividend), the mean, the square, the error and the tolerance test, and then
// raises out_valid. A new radicand is taken as soon as the previous one
// is finished, even while its result still waits in the output register;
// if that result is still stalled when the next one completes, the
// sequencer holds in its final state until the output register frees.
// Configuration: cfg_write with cfg_index 0 (tolerance) or 1 (iteration limit)
// and cfg_data, written by the user only while idle; the block does not enforce it.
// Reset (rst, synchronous) restores tolerance 2147 and limit 64, empties
// the output register and keeps in_stall high while asserted.
module newton_square_root (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [31:0]                     radicand,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [nsr_pkg::ROOT_W-1:0]      root,
  output logic [nsr_pkg::STEPS_W-1:0]     steps_used,
  output logic                            converged,
  input  logic                            cfg_write,
  input  logic [nsr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [nsr_pkg::CFG_W-1:0]       cfg_data
);

  logic [nsr_pkg::TOL_W-1:0]   tolerance;
  logic [nsr_pkg::STEPS_W-1:0] iteration_limit;
  nsr_pkg::dp_cmd_t            cmd;
  nsr_pkg::dp_status_t         status;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance       <= nsr_pkg::TOL_RESET;
      iteration_limit <= nsr_pkg::LIMIT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        nsr_pkg::REG_TOLERANCE:  tolerance       <= cfg_data[nsr_pkg::TOL_W-1:0];
        nsr_pkg::REG_ITER_LIMIT: iteration_limit <= cfg_data[nsr_pkg::STEPS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  nsr_ctrl u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .iteration_limit (iteration_limit),
    .status          (status),
    .cmd             (cmd),
    .steps_used      (steps_used),
    .converged       (converged)
  );

  nsr_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .radicand  (radicand),
    .tolerance (tolerance),
    .status    (status),
    .root      (root)
  );

endmodule
